// File: rtl/core/fptw_pkg.sv
// Shared types and constants for the four-level page table engine.
// No dependencies.
`default_nettype none
package fptw_pkg;

    localparam int ENTRY_W  = 64;
    localparam int NUMBER_W = 52;
    localparam int FLAGS_W  = 8;
    localparam int VADDR_W  = 48;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;

    localparam int DEF_LEVEL_BITS  = 9;
    localparam int DEF_OFFSET_BITS = 12;
    localparam int DEF_NODE_COUNT  = 16;

    localparam logic [FLAGS_W-1:0] FLAGS_RESET = 8'h01;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 2'd0,
        FN_LOOKUP = 2'd1,
        FN_REMOVE = 2'd2,
        FN_NONE   = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_EXHAUSTED  = 2'd1,
        ST_NOT_MAPPED = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_WAIT,
        S_FILL,
        S_DONE
    } state_t;

endpackage
`default_nettype wire

// File: rtl/core/fptw_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module fptw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/four_level_page_table_engine.sv
// Top level of the four-level page table engine: walk sequencer around the table RAM.
// Depends on fptw_pkg and fptw_ram.
//
// One beat in gives one beat out. Each level takes a RAM read issue (S_READ) and a
// registered read return (S_WAIT). Every node taken from the pool is swept, one word
// per cycle, 2^LEVEL_BITS words each (512 by default). After reset the root node is
// swept the same way before the first beat is accepted; config writes are
// taken only while the engine is idle.
`default_nettype none
module four_level_page_table_engine #(
    parameter int LEVEL_BITS  = fptw_pkg::DEF_LEVEL_BITS,
    parameter int OFFSET_BITS = fptw_pkg::DEF_OFFSET_BITS,
    parameter int NODE_COUNT  = fptw_pkg::DEF_NODE_COUNT
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [119:0] s_tdata,  // func[1:0], vaddr[49:2], page_word[113:50]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic      [63:0]  m_tdata,  // status[1:0], entry_number[53:2], entry_flags[61:54]
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [7:0]   cfg_data  // invalid_flags
);
    import fptw_pkg::*;

    localparam int NODE_W = $clog2(NODE_COUNT);
    localparam int USED_W = $clog2(NODE_COUNT + 1);
    localparam int ADDR_W = NODE_W + LEVEL_BITS;
    localparam int DEPTH  = NODE_COUNT * (1 << LEVEL_BITS);

    state_t               state_reg, state_next;
    logic [FUNC_W-1:0]    func_reg, func_next;
    logic [VADDR_W-1:0]   vaddr_reg, vaddr_next;
    logic [ENTRY_W-1:0]   page_reg, page_next;
    logic [1:0]           level_reg, level_next;
    logic [NODE_W-1:0]    node_reg, node_next;
    logic [USED_W-1:0]    used_reg, used_next;
    logic [LEVEL_BITS-1:0] cnt_reg, cnt_next;
    logic [FLAGS_W-1:0]   flags_reg;
    logic [STATUS_W-1:0]  rs_status_reg, rs_status_next;
    logic [NUMBER_W-1:0]  rs_number_reg, rs_number_next;
    logic [FLAGS_W-1:0]   rs_flags_reg, rs_flags_next;
    logic                 out_valid_reg, out_valid_next;
    logic [63:0]          out_data_reg, out_data_next;

    logic                 wr_en, rd_en;
    logic [ADDR_W-1:0]    wr_addr, rd_addr;
    logic [ENTRY_W-1:0]   wr_data, rd_data, fill_word;
    logic [63:0]          vext;
    logic [LEVEL_BITS-1:0] idx;
    logic                 child_ok;

    fptw_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign vext = {{(64-VADDR_W){1'b0}}, vaddr_reg};

    always_comb
    begin
        unique case (level_reg)
            2'd0: idx = vext[OFFSET_BITS + 3*LEVEL_BITS +: LEVEL_BITS];
            2'd1: idx = vext[OFFSET_BITS + 2*LEVEL_BITS +: LEVEL_BITS];
            2'd2: idx = vext[OFFSET_BITS + LEVEL_BITS +: LEVEL_BITS];
            2'd3: idx = vext[OFFSET_BITS +: LEVEL_BITS];
        endcase
    end

    assign child_ok  = (rd_data != '0) && (rd_data < ENTRY_W'(NODE_COUNT));
    assign fill_word = (level_reg == 2'd3) ?
                       {{(ENTRY_W-NUMBER_W-FLAGS_W){1'b0}}, flags_reg, {NUMBER_W{1'b0}}} :
                       '0;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign rd_en     = (state_reg == S_READ);
    assign rd_addr   = {node_reg, idx};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            used_reg      <= USED_W'(1);
            flags_reg     <= FLAGS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                flags_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        vaddr_reg     <= vaddr_next;
        page_reg      <= page_next;
        level_reg     <= level_next;
        node_reg      <= node_next;
        rs_status_reg <= rs_status_next;
        rs_number_reg <= rs_number_next;
        rs_flags_reg  <= rs_flags_next;
        out_data_reg  <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        vaddr_next     = vaddr_reg;
        page_next      = page_reg;
        level_next     = level_reg;
        node_next      = node_reg;
        used_next      = used_reg;
        cnt_next       = cnt_reg;
        rs_status_next = rs_status_reg;
        rs_number_next = rs_number_reg;
        rs_flags_next  = rs_flags_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        wr_en          = 1'b0;
        wr_addr        = {node_reg, idx};
        wr_data        = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = {{NODE_W{1'b0}}, cnt_reg};
                cnt_next = cnt_reg + 1'b1;
                if (&cnt_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    func_next      = s_tdata[1:0];
                    vaddr_next     = s_tdata[49:2];
                    page_next      = s_tdata[113:50];
                    level_next     = 2'd0;
                    node_next      = '0;
                    rs_status_next = ST_OK;
                    rs_number_next = '0;
                    rs_flags_next  = '0;
                    state_next     = (s_tdata[1:0] == FN_NONE) ? S_DONE : S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (level_reg == 2'd3)
                begin
                    state_next = S_DONE;
                    case (func_reg)
                        FN_INSERT:
                        begin
                            wr_en   = 1'b1;
                            wr_data = page_reg;
                        end
                        FN_REMOVE:
                        begin
                            wr_en = 1'b1;
                        end
                        default:
                        begin
                            rs_number_next = rd_data[NUMBER_W-1:0];
                            rs_flags_next  = rd_data[NUMBER_W +: FLAGS_W];
                        end
                    endcase
                end
                else if (child_ok)
                begin
                    node_next  = rd_data[NODE_W-1:0];
                    level_next = level_reg + 1'b1;
                    state_next = S_READ;
                end
                else if (func_reg != FN_INSERT)
                begin
                    rs_status_next = ST_NOT_MAPPED;
                    state_next     = S_DONE;
                end
                else if (used_reg == USED_W'(NODE_COUNT))
                begin
                    rs_status_next = ST_EXHAUSTED;
                    state_next     = S_DONE;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_data    = ENTRY_W'(used_reg);
                    node_next  = used_reg[NODE_W-1:0];
                    used_next  = used_reg + 1'b1;
                    level_next = level_reg + 1'b1;
                    cnt_next   = '0;
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                wr_en    = 1'b1;
                wr_addr  = {node_reg, cnt_reg};
                wr_data  = fill_word;
                cnt_next = cnt_reg + 1'b1;
                if (&cnt_reg)
                begin
                    state_next = S_READ;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {2'b00, rs_flags_reg, rs_number_reg, rs_status_reg};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: bench/four_level_page_table_engine_chk.sv
// Scoreboard for the four-level page table engine: watches the request, response
// and flag-register channels, keeps its own copy of the table and compares responses.
// Depends on fptw_pkg.
module four_level_page_table_engine_chk
    import fptw_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [119:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [63:0]  m_tdata,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [7:0]   cfg_data,
    output int           errors,
    output int           pending
);

    localparam int LVL_BITS   = DEF_LEVEL_BITS;
    localparam int OFS_BITS   = DEF_OFFSET_BITS;
    localparam int POOL_NODES = DEF_NODE_COUNT;
    localparam int NODE_WORDS = 1 << LVL_BITS;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [NUMBER_W-1:0] number;
        logic [FLAGS_W-1:0]  flags;
    } walk_result_t;

    logic [ENTRY_W-1:0] page_words [0:POOL_NODES*NODE_WORDS-1];
    int                 nodes_taken;
    logic [FLAGS_W-1:0] leaf_fill;
    walk_result_t       walk_results_q [$];

    function automatic int level_slot(logic [VADDR_W-1:0] va, int lv);
        return int'((va >> (OFS_BITS + (3 - lv) * LVL_BITS)) & (NODE_WORDS - 1));
    endfunction

    function automatic int child_node(logic [ENTRY_W-1:0] w);
        if (w == 0 || w >= POOL_NODES)
            return 0;
        return int'(w);
    endfunction

    function automatic int take_node(bit leaf);
        int n;
        logic [ENTRY_W-1:0] fill;
        if (nodes_taken >= POOL_NODES)
            return 0;
        n = nodes_taken;
        nodes_taken++;
        fill = leaf ? {4'h0, leaf_fill, 52'h0} : '0;
        for (int i = 0; i < NODE_WORDS; i++)
            page_words[n*NODE_WORDS + i] = fill;
        return n;
    endfunction

    // returns word address of the leaf entry, or -1 when a node is missing
    function automatic int leaf_word(logic [VADDR_W-1:0] va);
        int node;
        node = 0;
        for (int lv = 0; lv < 3; lv++)
        begin
            node = child_node(page_words[node*NODE_WORDS + level_slot(va, lv)]);
            if (node == 0)
                return -1;
        end
        return node*NODE_WORDS + level_slot(va, 3);
    endfunction

    function automatic walk_result_t walk(func_t fn, logic [VADDR_W-1:0] va,
                                          logic [ENTRY_W-1:0] pn);
        walk_result_t r;
        int node, pos, nxt, w;
        r = '0;
        r.status = ST_OK;
        case (fn)
            FN_INSERT:
            begin
                node = 0;
                for (int lv = 0; lv < 3 && r.status == ST_OK; lv++)
                begin
                    pos = node*NODE_WORDS + level_slot(va, lv);
                    nxt = child_node(page_words[pos]);
                    if (nxt == 0)
                    begin
                        nxt = take_node(lv == 2);
                        if (nxt == 0)
                            r.status = ST_EXHAUSTED;
                        else
                            page_words[pos] = nxt;
                    end
                    node = nxt;
                end
                if (r.status == ST_OK)
                    page_words[node*NODE_WORDS + level_slot(va, 3)] = pn;
            end
            FN_LOOKUP:
            begin
                w = leaf_word(va);
                if (w < 0)
                    r.status = ST_NOT_MAPPED;
                else
                begin
                    r.number = page_words[w][51:0];
                    r.flags  = page_words[w][59:52];
                end
            end
            FN_REMOVE:
            begin
                w = leaf_word(va);
                if (w < 0)
                    r.status = ST_NOT_MAPPED;
                else
                    page_words[w] = '0;
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        walk_result_t exp_r, got_r;
        if (!rst_n)
        begin
            for (int i = 0; i < POOL_NODES*NODE_WORDS; i++)
                page_words[i] = '0;
            nodes_taken = 1;
            leaf_fill   = FLAGS_RESET;
            walk_results_q.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                leaf_fill = cfg_data;
            if (s_tvalid && s_tready)
                walk_results_q.push_back(walk(func_t'(s_tdata[1:0]), s_tdata[49:2],
                                              s_tdata[113:50]));
            if (m_tvalid && m_tready)
            begin
                got_r.status = m_tdata[1:0];
                got_r.number = m_tdata[53:2];
                got_r.flags  = m_tdata[61:54];
                if (walk_results_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("[%0t] unexpected response beat %h", $realtime, m_tdata);
                end
                else
                begin
                    exp_r = walk_results_q.pop_front();
                    if (got_r !== exp_r)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("[%0t] mismatch: status %0d/%0d number %h/%h flags %h/%h",
                                     $realtime, exp_r.status, got_r.status, exp_r.number,
                                     got_r.number, exp_r.flags, got_r.flags);
                    end
                end
            end
            pending = walk_results_q.size();
        end
    end

endmodule

// File: bench/four_level_page_table_engine_tb.sv
// Testbench top for the four-level page table engine: clock, reset, request and
// flag-register stimulus, response back-pressure and the verdict.
// Depends on fptw_pkg, four_level_page_table_engine and four_level_page_table_engine_chk.
module four_level_page_table_engine_tb;
    import fptw_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [119:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [7:0]   cfg_data;
    int           errors;
    int           pending;
    bit           quiet;

    logic [26:0]  prefixes [0:4];

    four_level_page_table_engine dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    four_level_page_table_engine_chk chk (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("four_level_page_table_engine_tb: FAIL");
        $finish;
    end

    // response back-pressure
    initial
    begin
        m_tready = 0;
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 9) == 0)
            begin
                m_tready <= 0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
            end
            m_tready <= 1;
            repeat ($urandom_range(1, 30)) @(negedge clk);
        end
    end

    task automatic send_req(func_t fn, logic [47:0] va, logic [63:0] pn);
        @(negedge clk);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        s_tvalid <= 1;
        s_tdata  <= {6'h0, pn, va, fn};
        forever
        begin
            @(posedge clk);
            if (s_tready)
                break;
        end
    endtask

    task automatic drain;
        @(negedge clk);
        s_tvalid <= 0;
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_fill(logic [7:0] v);
        drain();
        @(negedge clk);
        cfg_valid <= 1;
        cfg_data  <= v;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    function automatic logic [63:0] rand64;
        return {$urandom, $urandom};
    endfunction

    function automatic logic [47:0] pick_addr(int n_pref);
        logic [8:0] leaf_ix;
        if ($urandom_range(0, 19) == 0)
            return 48'({$urandom, $urandom}); // noise anywhere in the space
        leaf_ix = ($urandom_range(0, 1) == 0) ? 9'($urandom_range(0, 15)) : 9'($urandom);
        return {prefixes[$urandom_range(0, n_pref - 1)], leaf_ix, 12'($urandom)};
    endfunction

    initial
    begin
        logic [47:0] va;
        logic [7:0]  fills [0:3];
        int          r;
        s_tvalid  = 0;
        s_tdata   = '0;
        cfg_valid = 0;
        cfg_data  = '0;
        quiet     = 0;
        rst_n     = 0;
        prefixes[0] = 27'($urandom);
        prefixes[1] = {prefixes[0][26:9], 9'($urandom)};
        prefixes[1][0] = ~prefixes[0][0];
        prefixes[2] = {prefixes[0][26:18], 18'($urandom)};
        prefixes[2][9] = ~prefixes[0][9];
        prefixes[3] = 27'($urandom);
        prefixes[4] = ~prefixes[3];
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: leaf filled with reset flag byte
        va = {prefixes[0], 9'd5, 12'hFFF};
        send_req(FN_INSERT, va, 64'hFFFF_FFFF_FFFF_FFFF);
        send_req(FN_LOOKUP, va, '0);
        send_req(FN_LOOKUP, {prefixes[0], 9'd6, 12'h000}, '0);
        send_req(FN_INSERT, {prefixes[0], 9'h1FF, 12'h000}, '0);
        send_req(FN_LOOKUP, {prefixes[0], 9'h1FF, 12'h000}, '0);
        send_req(FN_INSERT, {prefixes[0], 9'd0, 12'h000}, 64'h0FF0_0000_0000_0001);
        send_req(FN_LOOKUP, {prefixes[0], 9'd0, 12'h123}, rand64());
        send_req(FN_LOOKUP, 48'hFFFF_FFFF_FFFF, '0);
        send_req(FN_LOOKUP, 48'h0, '0);
        send_req(FN_REMOVE, 48'hFFFF_FFFF_FFFF, '0);
        send_req(FN_REMOVE, va, '0);
        send_req(FN_LOOKUP, va, '0);
        send_req(FN_NONE, 48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_req(FN_LOOKUP, va, '0);

        // directed: new leaf with all flags set, then none
        write_fill(8'hFF);
        send_req(FN_INSERT, {prefixes[1], 9'd1, 12'h0}, rand64());
        send_req(FN_LOOKUP, {prefixes[1], 9'd2, 12'h0}, '0);
        send_req(FN_REMOVE, {prefixes[1], 9'd2, 12'h0}, '0);
        send_req(FN_LOOKUP, {prefixes[1], 9'd2, 12'h0}, '0);
        write_fill(8'h00);
        send_req(FN_INSERT, {prefixes[2], 9'd3, 12'h0}, rand64());
        send_req(FN_LOOKUP, {prefixes[2], 9'd4, 12'h0}, '0);

        // random phases, one fill setting each; later phases reach more prefixes
        fills[0] = 8'($urandom);
        fills[1] = 8'hFF;
        fills[2] = 8'h00;
        fills[3] = 8'($urandom);
        for (int ph = 0; ph < 4; ph++)
        begin
            write_fill(fills[ph]);
            for (int i = 0; i < 320; i++)
            begin
                if (ph == 3 && i == 200)
                    quiet = 1;
                if (ph == 1 && i == 160)
                    drain();
                r = $urandom_range(0, 99);
                va = pick_addr(2 + ph);
                if (r < 40)
                    send_req(FN_INSERT, va, rand64());
                else if (r < 80)
                    send_req(FN_LOOKUP, va, rand64());
                else if (r < 97)
                    send_req(FN_REMOVE, va, rand64());
                else
                    send_req(FN_NONE, va, rand64());
            end
        end

        drain();
        repeat (600) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("four_level_page_table_engine_tb: PASS");
        else
            $display("four_level_page_table_engine_tb: FAIL");
        $finish;
    end

endmodule

// File: files.f
rtl/core/fptw_pkg.sv
rtl/core/fptw_ram.sv
rtl/core/four_level_page_table_engine.sv
bench/four_level_page_table_engine_chk.sv
bench/four_level_page_table_engine_tb.sv
